// ----- rtl/btb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_pkg: shared types and constants of the branch predictor
// Config register indexes, reset values and controller/datapath interface.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int DefTableEntries    = 32;
  localparam int DefCountersPerTable = 256;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INDEX_BITS     = 3'd0,
    CFG_HISTORY_BITS   = 3'd1,
    CFG_TAG_BITS       = 3'd2,
    CFG_INITIAL_STATE  = 3'd3,
    CFG_GLOBAL_HISTORY = 3'd4,
    CFG_GLOBAL_TABLE   = 3'd5,
    CFG_SHARE_MODE     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SHARE_NONE = 2'd0,
    SHARE_LOW  = 2'd1,
    SHARE_HIGH = 2'd2
  } share_e;

  localparam logic [2:0] RstIndexBits   = 3'd5;
  localparam logic [3:0] RstHistoryBits = 4'd8;
  localparam logic [4:0] RstTagBits     = 5'd20;
  localparam logic [1:0] RstInitState   = 2'd1;

  typedef struct packed {
    logic capture;
    logic entry_wr;
    logic cnt_clr;
    logic cnt_inc;
    logic init_wr;
    logic sweep_wr;
    logic mem_rd;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic row_last;
    logic all_last;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- rtl/btb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_ctrl: sequencer of the branch predictor
// Steps one item through lookup, optional row clear, counter read and update.
// ----------------------------------------------------------------------------
module btb_ctrl
  import btb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_SWEEP = 6'b001000,
    S_READ  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        // counter memory is swept to its reset value
        cmd_o.init_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.all_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.entry_wr = 1'b1;
        cmd_o.cnt_clr  = 1'b1;
        state_d = status_i.need_sweep ? S_SWEEP : S_READ;
      end
      S_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (status_i.row_last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

// ----- rtl/btb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_dp: datapath of the branch predictor
// Config registers, entry table, counter memory, totals and result register.
// ----------------------------------------------------------------------------
module btb_dp
  import btb_pkg::*;
#(
  parameter int TABLE_ENTRIES      = DefTableEntries,
  parameter int COUNTERS_PER_TABLE = DefCountersPerTable
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                cmd_i,
  input  logic [31:0]         pc_i,
  input  logic [31:0]         target_pc_i,
  input  logic                taken_i,
  input  logic [31:0]         earlier_prediction_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                predict_taken_o,
  output logic [31:0]         predicted_target_o,
  output logic [31:0]         branch_count_o,
  output logic [31:0]         flush_count_o,
  input  ctrl_cmd_t           cmd_ctl_i,
  output ctrl_status_t        status_o
);

  localparam int RowW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CiW   = (COUNTERS_PER_TABLE > 1) ? $clog2(COUNTERS_PER_TABLE) : 1;
  localparam int AddrW = RowW + CiW;

  // configuration
  logic [2:0] index_bits_q;
  logic [3:0] history_bits_q;
  logic [4:0] tag_bits_q;
  logic [1:0] init_state_q;
  logic       ghist_q, gtable_q;
  logic [1:0] share_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q   <= RstIndexBits;
      history_bits_q <= RstHistoryBits;
      tag_bits_q     <= RstTagBits;
      init_state_q   <= RstInitState;
      ghist_q        <= 1'b0;
      gtable_q       <= 1'b0;
      share_q        <= SHARE_NONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INDEX_BITS:     index_bits_q   <= cfg_data_i[2:0];
        CFG_HISTORY_BITS:   history_bits_q <= cfg_data_i[3:0];
        CFG_TAG_BITS:       tag_bits_q     <= cfg_data_i;
        CFG_INITIAL_STATE:  init_state_q   <= cfg_data_i[1:0];
        CFG_GLOBAL_HISTORY: ghist_q        <= cfg_data_i[0];
        CFG_GLOBAL_TABLE:   gtable_q       <= cfg_data_i[0];
        CFG_SHARE_MODE:     share_q        <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        cmd_q, taken_q;
  logic [31:0] pc_q, tgt_q, early_q;

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.capture) begin
      cmd_q   <= cmd_i;
      pc_q    <= pc_i;
      tgt_q   <= target_pc_i;
      taken_q <= taken_i;
      early_q <= earlier_prediction_i;
    end
  end

  // effective field widths
  logic [2:0] ib;
  logic [3:0] hb;
  logic [4:0] tb;
  logic [4:0] imask, masked_idx;
  logic [7:0] hmask;
  logic [29:0] tmask, tag;
  logic [31:0] tag_src;
  logic [RowW-1:0] row;

  always_comb begin
    ib = (index_bits_q == 3'd0) ? 3'd1 : ((index_bits_q > 3'd5) ? 3'd5 : index_bits_q);
    hb = (history_bits_q == 4'd0) ? 4'd1 :
         ((history_bits_q > 4'd8) ? 4'd8 : history_bits_q);
    tb = (tag_bits_q > (5'd30 - 5'(ib))) ? (5'd30 - 5'(ib)) : tag_bits_q;
    imask = 5'((6'd1 << ib) - 6'd1);
    hmask = 8'((9'd1 << hb) - 9'd1);
    tmask = (30'd1 << tb) - 30'd1;
    tag_src = pc_q >> (6'd2 + 6'(ib));
    tag = tag_src[29:0] & tmask;
    masked_idx = pc_q[6:2] & imask;
    row = '0;
    for (int i = 0; i < 32; i++) begin
      if (masked_idx == 5'(i)) row = RowW'(i % TABLE_ENTRIES);
    end
  end

  // entry table
  logic        valid_q [TABLE_ENTRIES];
  logic [29:0] etag_q  [TABLE_ENTRIES];
  logic [31:0] etgt_q  [TABLE_ENTRIES];
  logic [7:0]  ehist_q [TABLE_ENTRIES];
  logic [7:0]  shist_q;

  logic       hit;
  logic [7:0] hist, hist_new, cvec;
  logic [CiW-1:0]   ci;
  logic [AddrW-1:0] ctr_addr;

  always_comb begin
    hit  = valid_q[row] && (etag_q[row] == tag);
    hist = ghist_q ? shist_q : ehist_q[row];
    cvec = hist & hmask;
    if (gtable_q) begin
      if (share_q == SHARE_LOW) cvec = cvec ^ (pc_q[9:2] & hmask);
      else if (share_q == SHARE_HIGH) cvec = cvec ^ (pc_q[23:16] & hmask);
    end
    ci = '0;
    for (int i = 0; i < 256; i++) begin
      if (cvec == 8'(i)) ci = CiW'(i % COUNTERS_PER_TABLE);
    end
    ctr_addr = {(gtable_q ? RowW'(0) : row), ci};
    hist_new = ((hist << 1) | 8'(taken_q)) & hmask;
  end

  logic upd_fin, alloc;
  assign upd_fin = cmd_ctl_i.finish && cmd_q;
  assign alloc   = cmd_ctl_i.entry_wr && cmd_q && !hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shist_q <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        ehist_q[i] <= '0;
      end
    end else begin
      if (alloc) begin
        valid_q[row] <= 1'b1;
        if (!ghist_q) ehist_q[row] <= '0;
      end
      if (upd_fin) begin
        if (ghist_q) shist_q <= hist_new;
        else ehist_q[row] <= hist_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc) begin
      etag_q[row] <= tag;
      etgt_q[row] <= tgt_q;
    end
  end

  // counter memory and sweep counter
  logic [AddrW-1:0] cnt_q;
  logic [1:0] ctr_mem [2**AddrW];
  logic [1:0] rdata_q, ctr_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_ctl_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_ctl_i.cnt_inc) begin
      cnt_q <= cnt_q + AddrW'(1);
    end
  end

  always_comb begin
    if (taken_q) ctr_new = (rdata_q == 2'd3) ? 2'd3 : rdata_q + 2'd1;
    else ctr_new = (rdata_q == 2'd0) ? 2'd0 : rdata_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.init_wr) begin
      ctr_mem[cnt_q] <= RstInitState;
    end else if (cmd_ctl_i.sweep_wr) begin
      ctr_mem[{row, cnt_q[CiW-1:0]}] <= init_state_q;
    end else if (upd_fin) begin
      ctr_mem[ctr_addr] <= ctr_new;
    end
    if (cmd_ctl_i.mem_rd) rdata_q <= ctr_mem[ctr_addr];
  end

  // totals and result register
  logic [31:0] btot_q, ftot_q, btot_d, ftot_d;
  logic        flush;
  logic        out_valid_q;

  assign flush  = taken_q ? (tgt_q != early_q) : (tgt_q == early_q);
  assign btot_d = btot_q + 32'd1;
  assign ftot_d = flush ? ftot_q + 32'd1 : ftot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btot_q      <= '0;
      ftot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (upd_fin) begin
        btot_q <= btot_d;
        ftot_q <= ftot_d;
      end
      if (cmd_ctl_i.finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.finish) begin
      if (cmd_q) begin
        predict_taken_o    <= 1'b0;
        predicted_target_o <= '0;
        branch_count_o     <= btot_d;
        flush_count_o      <= ftot_d;
      end else begin
        predict_taken_o    <= hit && rdata_q[1];
        predicted_target_o <= (hit && rdata_q[1]) ? etgt_q[row] : pc_q + 32'd4;
        branch_count_o     <= btot_q;
        flush_count_o      <= ftot_q;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.need_sweep = cmd_q && !hit && !gtable_q;
  assign status_o.row_last   = (cnt_q[CiW-1:0] == CiW'(COUNTERS_PER_TABLE - 1));
  assign status_o.all_last   = (cnt_q == {AddrW{1'b1}});
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ----- rtl/btb_two_level_branch_predictor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_top: BTB with two-level direction predictor
// Direct-mapped target buffer plus 2-bit counters selected by history.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_i... driven here as in_stall_o)
//   carries one command item: predict (cmd 0) or update (cmd 1). Each item
//   yields exactly one result item on the output channel (out_valid_o /
//   out_stall_i) with direction, next address and the two running totals.
//   After acceptance the item passes lookup, counter read and update before
//   its result appears; a new item is accepted only once the previous one
//   has finished. An update that allocates an entry with per-entry counter
//   tables first refills that row of the counter memory, one counter per
//   cycle through its single port.
//   One item is in flight at a time; the result register lets the next item
//   be accepted while the previous result is still stalled.
//   After reset the counter memory is swept to its reset value, one entry per
//   cycle, 2**(clog2(TABLE_ENTRIES)+clog2(COUNTERS_PER_TABLE)) entries (8192
//   by default); in_stall_o stays high meanwhile, config writes are taken.
//   A stalled result holds; the block finishes the current item only once
//   the result register is free.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_top
  import btb_pkg::*;
#(
  parameter int TABLE_ENTRIES      = DefTableEntries,
  parameter int COUNTERS_PER_TABLE = DefCountersPerTable
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [31:0]         pc_i,
  input  logic [31:0]         target_pc_i,
  input  logic                taken_i,
  input  logic [31:0]         earlier_prediction_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                predict_taken_o,
  output logic [31:0]         predicted_target_o,
  output logic [31:0]         branch_count_o,
  output logic [31:0]         flush_count_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  btb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  btb_dp #(
    .TABLE_ENTRIES      (TABLE_ENTRIES),
    .COUNTERS_PER_TABLE (COUNTERS_PER_TABLE)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .cmd_i                (cmd_i),
    .pc_i                 (pc_i),
    .target_pc_i          (target_pc_i),
    .taken_i              (taken_i),
    .earlier_prediction_i (earlier_prediction_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .predict_taken_o      (predict_taken_o),
    .predicted_target_o   (predicted_target_o),
    .branch_count_o       (branch_count_o),
    .flush_count_o        (flush_count_o),
    .cmd_ctl_i            (cmd),
    .status_o             (status)
  );

endmodule

// ----- rtl/btb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_checker: port-level checks of the branch predictor
// Watches handshakes and item sequencing on the top level.
// ----------------------------------------------------------------------------
module btb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item in work at a time, stall stays raised after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("item accepted while busy");

  // a new result only appears at the end of an item's work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

endmodule

bind btb_two_level_branch_predictor_top btb_checker u_btb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the two-level branch predictor with target buffer
// Drives predict and update items through the valid/stall channel, predicts
// every result with an in-bench model of the tables and checks each output
// item field by field, across several register settings and backpressure.
// ----------------------------------------------------------------------------
module tb;
  import btb_pkg::*;

  localparam int HoldCycles = 300;
  localparam int DrainCycles = 300;
  localparam int WatchLimit = 40000;

  typedef struct {
    logic        ptaken;
    logic [31:0] ptarget;
    logic [31:0] branches;
    logic [31:0] flushes;
  } bp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [31:0] pc_i = '0;
  logic [31:0] target_pc_i = '0;
  logic taken_i = 1'b0;
  logic [31:0] earlier_prediction_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic predict_taken_o;
  logic [31:0] predicted_target_o;
  logic [31:0] branch_count_o;
  logic [31:0] flush_count_o;

  btb_two_level_branch_predictor_top dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [2:0]  m_index_bits;
  logic [3:0]  m_history_bits;
  logic [4:0]  m_tag_bits;
  logic [1:0]  m_init_state;
  logic        m_global_hist;
  logic        m_global_table;
  logic [1:0]  m_share;
  logic        m_valid [32];
  logic [31:0] m_tag [32];
  logic [31:0] m_target [32];
  logic [7:0]  m_hist [32];
  logic [7:0]  m_shared_hist;
  logic [1:0]  m_ctr [32][256];
  logic [31:0] m_branches;
  logic [31:0] m_flushes;

  bp_result_t expected_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  logic [31:0] pc_pool [8];

  task automatic predict_branch(input logic cmd, input logic [31:0] pc, input logic [31:0] tgt,
                                input logic tk, input logic [31:0] early);
    int ib, hb, tb, row, tbl, ci;
    logic [31:0] mask, tg, h, v;
    bit hit;
    bp_result_t r;
    ib = (m_index_bits < 1) ? 1 : (m_index_bits > 5) ? 5 : m_index_bits;
    hb = (m_history_bits < 1) ? 1 : (m_history_bits > 8) ? 8 : m_history_bits;
    mask = (32'd1 << hb) - 1;
    row = (pc >> 2) & ((32'd1 << ib) - 1);
    tb = (m_tag_bits > 30 - ib) ? 30 - ib : m_tag_bits;
    tg = (pc >> (2 + ib)) & ((32'd1 << tb) - 1);
    tbl = m_global_table ? 0 : row;
    hit = m_valid[row] && (m_tag[row] == tg);
    r.ptaken = 1'b0;
    r.ptarget = '0;
    if (cmd == 1'b0) begin
      h = m_global_hist ? m_shared_hist : m_hist[row];
    end else begin
      m_branches++;
      if (tk ? (tgt != early) : (tgt == early)) m_flushes++;
      if (!hit) begin
        m_tag[row] = tg;
        m_valid[row] = 1'b1;
        m_target[row] = tgt;
        if (!m_global_hist) m_hist[row] = '0;
        if (!m_global_table) for (int k = 0; k < 256; k++) m_ctr[row][k] = m_init_state;
      end
      h = m_global_hist ? m_shared_hist : m_hist[row];
    end
    v = h & mask;
    if (m_global_table) begin
      if (m_share == SHARE_LOW) v ^= (pc >> 2) & mask;
      else if (m_share == SHARE_HIGH) v ^= (pc >> 16) & mask;
    end
    ci = v[7:0];
    if (cmd == 1'b0) begin
      if (hit && m_ctr[tbl][ci] >= 2) begin
        r.ptaken = 1'b1;
        r.ptarget = m_target[row];
      end else begin
        r.ptarget = pc + 32'd4;
      end
    end else begin
      if (tk && m_ctr[tbl][ci] < 3) m_ctr[tbl][ci]++;
      else if (!tk && m_ctr[tbl][ci] > 0) m_ctr[tbl][ci]--;
      h = ((h << 1) | tk) & mask;
      if (m_global_hist) m_shared_hist = h[7:0];
      else m_hist[row] = h[7:0];
    end
    r.branches = m_branches;
    r.flushes = m_flushes;
    expected_q.push_back(r);
  endtask

  // call at a rising edge
  task automatic send_item(input logic cmd, input logic [31:0] pc, input logic [31:0] tgt,
                           input logic tk, input logic [31:0] early);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    pc_i <= pc;
    target_pc_i <= tgt;
    taken_i <= tk;
    earlier_prediction_i <= early;
    do @(posedge clk_i); while (in_stall_o);
    predict_branch(cmd, pc, tgt, tk, early);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [4:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INDEX_BITS:     m_index_bits = data[2:0];
      CFG_HISTORY_BITS:   m_history_bits = data[3:0];
      CFG_TAG_BITS:       m_tag_bits = data;
      CFG_INITIAL_STATE:  m_init_state = data[1:0];
      CFG_GLOBAL_HISTORY: m_global_hist = data[0];
      CFG_GLOBAL_TABLE:   m_global_table = data[0];
      CFG_SHARE_MODE:     m_share = data[1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [4:0] ib, hb, tb, ist, gh, gt, sm);
    write_reg(CFG_INDEX_BITS, ib);
    write_reg(CFG_HISTORY_BITS, hb);
    write_reg(CFG_TAG_BITS, tb);
    write_reg(CFG_INITIAL_STATE, ist);
    write_reg(CFG_GLOBAL_HISTORY, gh);
    write_reg(CFG_GLOBAL_TABLE, gt);
    write_reg(CFG_SHARE_MODE, sm);
  endtask

  task automatic send_random(input int n);
    logic [31:0] pc, tgt, early;
    logic tk, cmd;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        // noise item, every field random
        send_item(1'($urandom_range(1)), $urandom, $urandom, 1'($urandom_range(1)), $urandom);
      end else begin
        pc = pc_pool[$urandom_range(7)];
        cmd = 1'($urandom_range(1));
        tk = ($urandom_range(99) < 65);
        tgt = ($urandom_range(3) == 0) ? $urandom : {pc[31:12], pc[11:0] ^ 12'h400};
        early = $urandom_range(1) ? tgt : pc + 32'd4;
        send_item(cmd, pc, tgt, tk, early);
      end
    end
  endtask

  task automatic new_pool();
    logic [31:0] base;
    base = $urandom;
    for (int k = 0; k < 8; k++)
      pc_pool[k] = ($urandom_range(3) == 0) ? $urandom : base ^ ($urandom_range(15) << 2);
  endtask

  task automatic test_directed();
    quiet = 1'b1;
    send_item(1'b0, 32'h0000_0000, 32'h0, 1'b0, 32'h0);
    send_item(1'b0, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
    send_item(1'b1, 32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_1004);
    send_item(1'b0, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    send_item(1'b1, 32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_2000);
    send_item(1'b1, 32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_2000);
    send_item(1'b1, 32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_2000);
    send_item(1'b0, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    // not taken with matching target counts as a flush
    send_item(1'b1, 32'h0000_1000, 32'h0000_3000, 1'b0, 32'h0000_3000);
    send_item(1'b1, 32'h0000_1000, 32'h0000_3000, 1'b0, 32'h0000_1004);
    // same row, different tag reallocates
    send_item(1'b1, 32'h0010_1000, 32'hFFFF_FFFF, 1'b1, 32'h0);
    send_item(1'b0, 32'h0010_1000, 32'h0, 1'b0, 32'h0);
    send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h1);
    send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(1'b0, 32'hFFFF_FFFE, 32'h0, 1'b0, 32'h0);
    send_item(1'b1, 32'h0000_0000, 32'h0, 1'b0, 32'h0);
    send_item(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_settings();
    logic [4:0] tbl [6][7] = '{
      '{5'd1, 5'd1, 5'd0,  5'd0, 5'd0, 5'd0, 5'd0},
      '{5'd5, 5'd8, 5'd29, 5'd3, 5'd1, 5'd1, 5'd1},
      '{5'd2, 5'd4, 5'd31, 5'd2, 5'd0, 5'd1, 5'd2},
      '{5'd0, 5'd0, 5'd10, 5'd1, 5'd1, 5'd0, 5'd3},
      '{5'd7, 5'd15, 5'd25, 5'd0, 5'd1, 5'd1, 5'd2},
      '{5'd3, 5'd9, 5'd5,  5'd3, 5'd0, 5'd1, 5'd1}};
    for (int p = 0; p < 9; p++) begin
      if (p < 6) write_all(tbl[p][0], tbl[p][1], tbl[p][2], tbl[p][3], tbl[p][4], tbl[p][5],
                           tbl[p][6]);
      else write_all(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                     5'($urandom), 5'($urandom));
      new_pool();
      // one stretch without idling on either side
      quiet = (p == 2);
      send_random(65);
      quiet = 1'b0;
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    write_all(5'd2, 5'd3, 5'd4, 5'd2, 5'd1, 5'd1, 5'd0);
    new_pool();
    hold_req = 1'b1;
    send_random(20);
    wait_drained();
  endtask

  task automatic test_pause();
    new_pool();
    send_random(15);
    // sender waits for every result before going on
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    send_random(15);
    wait_drained();
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 17);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    bp_result_t e;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: taken %0d target %h", predict_taken_o,
                                   predicted_target_o);
      end else begin
        e = expected_q.pop_front();
        if (predict_taken_o !== e.ptaken || predicted_target_o !== e.ptarget ||
            branch_count_o !== e.branches || flush_count_o !== e.flushes) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %h %0d %0d got %0d %h %0d %0d", e.ptaken, e.ptarget,
                     e.branches, e.flushes, predict_taken_o, predicted_target_o,
                     branch_count_o, flush_count_o);
        end
      end
    end
  end

  initial begin
    m_index_bits = RstIndexBits;
    m_history_bits = RstHistoryBits;
    m_tag_bits = RstTagBits;
    m_init_state = RstInitState;
    m_global_hist = 1'b0;
    m_global_table = 1'b0;
    m_share = SHARE_NONE;
    m_shared_hist = '0;
    m_branches = '0;
    m_flushes = '0;
    for (int r = 0; r < 32; r++) begin
      m_valid[r] = 1'b0;
      m_tag[r] = '0;
      m_target[r] = '0;
      m_hist[r] = '0;
      for (int k = 0; k < 256; k++) m_ctr[r][k] = RstInitState;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_backpressure();
    test_pause();
    if (errors == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- btb_two_level_branch_predictor_top.f -----
rtl/btb_pkg.sv
rtl/btb_ctrl.sv
rtl/btb_dp.sv
rtl/btb_two_level_branch_predictor_top.sv
rtl/btb_checker.sv
verif/tb.sv
